FILE: src/ips_pkg.sv
package ips_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RT_W     = 24;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PW_L_W = 26;
  localparam int unsigned PW_T_W = 18;
  localparam int unsigned PW_H_W = 17;
  localparam int unsigned WSUM_W = 9;
  localparam int unsigned TERM_W = 40;
  localparam int unsigned SUM_W  = 41;
  localparam int unsigned DEN_W  = 40;
  localparam int unsigned PP_W   = 44;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned QUO_W  = 32;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    OP_EVALUATE   = 2'd0,
    OP_FORCE_RUN  = 2'd1,
    OP_FORCE_STOP = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ENABLED     = 3'd0,
    REG_THRESHOLDS  = 3'd1,
    REG_WEIGHTS     = 3'd2,
    REG_BASE_RT     = 3'd3,
    REG_PERIOD      = 3'd4,
    REG_RT_LIMITS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [31:0]       now_ms;
    logic [6:0]        humidity;
    logic signed [7:0] temperature;
    logic [11:0]       soil_moisture;
    logic [15:0]       light;
  } in_item_t;

  typedef struct packed {
    logic        pump_on;
    logic [23:0] runtime_ms;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic term;
    logic sum;
    logic pprod;
    logic num;
    logic dinit;
    logic dstep;
    logic clamp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_eval;
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_TERM,
    ST_SUM,
    ST_PPROD,
    ST_NUM,
    ST_DINIT,
    ST_DIV,
    ST_CLAMP,
    ST_FINAL
  } ctl_state_t;

endpackage

FILE: src/ips_ctrl.sv
module ips_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ips_pkg::dp_sts_t  sts,
  output ips_pkg::dp_cmd_t  cmd
);

  ips_pkg::ctl_state_t state_r, state_nxt;
  logic [ips_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ips_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      ips_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ips_pkg::ST_PROD;
        end
      end
      ips_pkg::ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = sts.is_eval ? ips_pkg::ST_TERM : ips_pkg::ST_FINAL;
      end
      ips_pkg::ST_TERM: begin
        cmd.term  = 1'b1;
        state_nxt = ips_pkg::ST_SUM;
      end
      ips_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ips_pkg::ST_PPROD;
      end
      ips_pkg::ST_PPROD: begin
        cmd.pprod = 1'b1;
        state_nxt = ips_pkg::ST_NUM;
      end
      ips_pkg::ST_NUM: begin
        cmd.num   = 1'b1;
        state_nxt = ips_pkg::ST_DINIT;
      end
      ips_pkg::ST_DINIT: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ips_pkg::ST_DIV;
      end
      ips_pkg::ST_DIV: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ips_pkg::DIV_CNT_W'(ips_pkg::DIV_STEPS - 1)) begin
          state_nxt = ips_pkg::ST_CLAMP;
        end
      end
      ips_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ips_pkg::ST_FINAL;
      end
      ips_pkg::ST_FINAL: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ips_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ips_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/ips_datapath.sv
module ips_datapath #(
  parameter int LIGHT_LOW     = 0,
  parameter int LIGHT_HIGH    = 4095,
  parameter int TEMP_LOW      = 0,
  parameter int TEMP_HIGH     = 40,
  parameter int HUMIDITY_LOW  = 0,
  parameter int HUMIDITY_HIGH = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ips_pkg::in_item_t                 in_data,
  input  logic                              cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ips_pkg::CFG_W-1:0]         cfg_data,
  input  ips_pkg::dp_cmd_t                  cmd,
  output ips_pkg::dp_sts_t                  sts,
  output ips_pkg::out_item_t                out_data
);

  localparam int DL = LIGHT_HIGH - LIGHT_LOW;
  localparam int DT = TEMP_HIGH - TEMP_LOW;
  localparam int DH = HUMIDITY_HIGH - HUMIDITY_LOW;
  localparam int KL = DT * DH;
  localparam int KT = DL * DH;
  localparam int KH = DL * DT;
  localparam int KD = DL * DT * DH;

  localparam logic signed [17:0] LL_S = 18'(LIGHT_LOW);
  localparam logic signed [9:0]  TL_S = 10'(TEMP_LOW);
  localparam logic signed [8:0]  HL_S = 9'(HUMIDITY_LOW);
  localparam logic signed [15:0] KL_S = 16'(KL);
  localparam logic signed [23:0] KT_S = 24'(KT);
  localparam logic signed [24:0] KH_S = 25'(KH);
  localparam logic [30:0]        KD_U = 31'(KD);
  localparam logic               KD_POS = (KD > 0);

  logic        en_r;
  logic [42:0] thr_r;
  logic [20:0] wgt_r;
  logic [23:0] base_r;
  logic [31:0] period_r;
  logic [47:0] lim_r;
  logic        force_r, force_nxt;
  logic [31:0] last_r, last_nxt;

  ips_pkg::in_item_t  item_r;
  ips_pkg::out_item_t out_r, out_nxt;

  logic signed [ips_pkg::PW_L_W-1:0] pw_l_r;
  logic signed [ips_pkg::PW_T_W-1:0] pw_t_r;
  logic signed [ips_pkg::PW_H_W-1:0] pw_h_r;
  logic [ips_pkg::WSUM_W-1:0]        wsum_r;
  logic signed [ips_pkg::TERM_W-1:0] t_l_r, t_t_r, t_h_r;
  logic [ips_pkg::DEN_W-1:0]         den_r;
  logic signed [ips_pkg::SUM_W-1:0]  s_r;
  logic                              s_pos_r;
  logic [ips_pkg::PP_W-1:0]          pp_lo_r, pp_hi_r;
  logic [ips_pkg::NUM_W-1:0]         n_r;
  logic [ips_pkg::DEN_W-1:0]         rem_r;
  logic [ips_pkg::QUO_W-1:0]         quo_r;
  logic                              sat_r, zero_r;
  logic [ips_pkg::RT_W-1:0]          runtime_r;
  logic [31:0]                       start_r;

  logic signed [17:0] pl;
  logic signed [9:0]  pt;
  logic signed [8:0]  ph;
  logic [6:0]         wl, wt, wh;
  logic [ips_pkg::DEN_W+1:0] diff;
  logic                      ge;
  logic                      elig;
  logic [31:0]               raw;
  logic [23:0]               capped, clamped, lo_lim, hi_lim;
  logic [31:0]               end_ms;

  assign wl = wgt_r[6:0];
  assign wt = wgt_r[13:7];
  assign wh = wgt_r[20:14];

  assign pl = $signed({2'b00, item_r.light}) - LL_S;
  assign pt = $signed({{2{item_r.temperature[7]}}, item_r.temperature}) - TL_S;
  assign ph = $signed({2'b00, item_r.humidity}) - HL_S;

  assign diff = {1'b0, rem_r, quo_r[ips_pkg::QUO_W-1]} - {2'b00, den_r};
  assign ge   = ~diff[ips_pkg::DEN_W+1];

  assign elig = en_r && (force_r ||
                ((item_r.humidity <= thr_r[6:0]) &&
                 ($signed(item_r.temperature) >= $signed(thr_r[14:7])) &&
                 (item_r.soil_moisture <= thr_r[26:15]) &&
                 (item_r.light >= thr_r[42:27])));

  assign lo_lim  = lim_r[23:0];
  assign hi_lim  = lim_r[47:24];
  assign raw     = zero_r ? '0 : (sat_r ? '1 : quo_r);
  assign capped  = (raw < {8'b0, hi_lim}) ? raw[23:0] : hi_lim;
  assign clamped = (capped < lo_lim) ? lo_lim : capped;

  assign end_ms = start_r + {8'b0, runtime_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      thr_r    <= '0;
      wgt_r    <= '0;
      base_r   <= '0;
      period_r <= '0;
      lim_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ips_pkg::REG_ENABLED:    en_r     <= cfg_data[0];
        ips_pkg::REG_THRESHOLDS: thr_r    <= cfg_data[42:0];
        ips_pkg::REG_WEIGHTS:    wgt_r    <= cfg_data[20:0];
        ips_pkg::REG_BASE_RT:    base_r   <= cfg_data[23:0];
        ips_pkg::REG_PERIOD:     period_r <= cfg_data[31:0];
        ips_pkg::REG_RT_LIMITS:  lim_r    <= cfg_data[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    force_nxt = force_r;
    last_nxt  = last_r;
    out_nxt   = out_r;
    if (cmd.finish) begin
      out_nxt = '0;
      unique case (item_r.opcode)
        ips_pkg::OP_EVALUATE: begin
          if (runtime_r == '0) begin
            last_nxt = item_r.now_ms;
          end else begin
            out_nxt.runtime_ms = runtime_r;
            if ((item_r.now_ms > start_r) && (item_r.now_ms < end_ms)) begin
              out_nxt.pump_on = 1'b1;
            end else if (item_r.now_ms > end_ms) begin
              last_nxt  = item_r.now_ms;
              force_nxt = 1'b0;
            end
          end
        end
        ips_pkg::OP_FORCE_RUN: begin
          force_nxt = 1'b1;
          last_nxt  = item_r.now_ms - period_r;
        end
        ips_pkg::OP_FORCE_STOP: begin
          force_nxt = 1'b0;
          last_nxt  = item_r.now_ms;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r <= 1'b0;
      last_r  <= '0;
    end else begin
      force_r <= force_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.prod) begin
      pw_l_r <= ips_pkg::PW_L_W'(pl) * ips_pkg::PW_L_W'($signed({1'b0, wl}));
      pw_t_r <= ips_pkg::PW_T_W'(pt) * ips_pkg::PW_T_W'($signed({1'b0, wt}));
      pw_h_r <= ips_pkg::PW_H_W'(ph) * ips_pkg::PW_H_W'($signed({1'b0, wh}));
      wsum_r <= ips_pkg::WSUM_W'(wl) + ips_pkg::WSUM_W'(wt) + ips_pkg::WSUM_W'(wh);
    end
    if (cmd.term) begin
      t_l_r <= ips_pkg::TERM_W'(pw_l_r) * ips_pkg::TERM_W'(KL_S);
      t_t_r <= ips_pkg::TERM_W'(pw_t_r) * ips_pkg::TERM_W'(KT_S);
      t_h_r <= ips_pkg::TERM_W'(pw_h_r) * ips_pkg::TERM_W'(KH_S);
      den_r <= {31'b0, wsum_r} * {9'b0, KD_U};
    end
    if (cmd.sum) begin
      s_r <= $signed({t_l_r[ips_pkg::TERM_W-1], t_l_r}) +
             $signed({t_t_r[ips_pkg::TERM_W-1], t_t_r}) +
             $signed({t_h_r[ips_pkg::TERM_W-1], t_h_r});
    end
    if (cmd.pprod) begin
      s_pos_r <= ~s_r[ips_pkg::SUM_W-1] && (s_r != '0);
      pp_lo_r <= ips_pkg::PP_W'(base_r) * ips_pkg::PP_W'(s_r[19:0]);
      pp_hi_r <= ips_pkg::PP_W'(base_r) * ips_pkg::PP_W'(s_r[39:20]);
    end
    if (cmd.num) begin
      n_r <= {pp_hi_r, 20'b0} + ips_pkg::NUM_W'(pp_lo_r);
    end
    if (cmd.dinit) begin
      rem_r  <= {8'b0, n_r[63:32]};
      quo_r  <= n_r[31:0];
      sat_r  <= {8'b0, n_r[63:32]} >= den_r;
      zero_r <= (den_r == '0) || !s_pos_r || !KD_POS;
    end
    if (cmd.dstep) begin
      rem_r <= ge ? diff[ips_pkg::DEN_W-1:0]
                  : {rem_r[ips_pkg::DEN_W-2:0], quo_r[ips_pkg::QUO_W-1]};
      quo_r <= {quo_r[ips_pkg::QUO_W-2:0], ge};
    end
    if (cmd.clamp) begin
      runtime_r <= !elig ? '0 : (force_r ? base_r : clamped);
      start_r   <= period_r + last_r;
    end
  end

  assign sts.is_eval = (item_r.opcode == ips_pkg::OP_EVALUATE);
  assign out_data    = out_r;

endmodule

FILE: src/irrigation_pump_scheduler_core.sv
// An evaluate transaction passes through the states PROD, TERM, SUM, PPROD, NUM,
// DINIT, DIV, CLAMP and FINAL; force run, force stop and unused opcodes go from PROD
// straight to FINAL. A new transaction is accepted only after the result has left
// FINAL; the 32-step radix-2 divider normalises the weighted sensor sum.
// Reset (rst_n, synchronous, active low) clears the configuration registers, the
// schedule state and the output valid; no clearing pass is needed.
module irrigation_pump_scheduler_core #(
  parameter int LIGHT_LOW     = 0,
  parameter int LIGHT_HIGH    = 4095,
  parameter int TEMP_LOW      = 0,
  parameter int TEMP_HIGH     = 40,
  parameter int HUMIDITY_LOW  = 0,
  parameter int HUMIDITY_HIGH = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ips_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ips_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ips_pkg::CFG_W-1:0]     cfg_data
);

  ips_pkg::dp_cmd_t cmd;
  ips_pkg::dp_sts_t sts;

  ips_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ips_datapath #(
    .LIGHT_LOW     (LIGHT_LOW),
    .LIGHT_HIGH    (LIGHT_HIGH),
    .TEMP_LOW      (TEMP_LOW),
    .TEMP_HIGH     (TEMP_HIGH),
    .HUMIDITY_LOW  (HUMIDITY_LOW),
    .HUMIDITY_HIGH (HUMIDITY_HIGH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

FILE: src/ips_checker.sv
module ips_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ips_pkg::out_item_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input side did not go busy after a transaction was accepted.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("A result appeared without a transaction in progress.");

  a_on_needs_runtime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pump_on) |-> (out_data.runtime_ms != '0))
    else $error("Pump reported on with a zero runtime.");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("Result valid dropped while stalled.");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

endmodule

bind irrigation_pump_scheduler_core ips_checker u_ips_checker (.*);
